@@ rtl/lgti_pkg.sv @@
// Shared types, constants and helper functions of the LOD grid triangle index generator.
package lgti_pkg;

   // Fixed field and counter widths.
   localparam int VERTEX_W    = 17;
   localparam int CNT_W       = 9;
   localparam int PHASE_W     = 8;
   localparam int DETAIL_W    = 8;
   localparam int SIZE_W      = 4;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 8;
   localparam int GROUP_W     = 4;
   localparam int GROUP_N     = 16;
   // Width of a grid coordinate before it is clamped to the grid.
   localparam int CW          = 20;

   localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(4);

   typedef enum logic [1:0] {
      SEC_WEDGE,
      SEC_STITCH,
      SEC_INTERIOR,
      SEC_BORDER
   } section_type;

   typedef enum logic [1:0] {
      SIDE_NORTH,
      SIDE_SOUTH,
      SIDE_WEST,
      SIDE_EAST
   } side_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SIZE_LOG2,
      CSR_NORTH,
      CSR_SOUTH,
      CSR_WEST,
      CSR_EAST
   } csr_index_type;

   typedef logic [DETAIL_W-1:0] detail_type;
   typedef logic [GROUP_W-1:0]  group_type;

   localparam group_type START_GROUP = '0;

   // Position in the triangle list.
   typedef struct packed {
      section_type         sec;
      side_type            side;
      logic [CNT_W-1:0]    row;
      logic [CNT_W-1:0]    col;
      logic                half;
      logic [CNT_W-1:0]    base;
      logic [PHASE_W-1:0]  phase;
   } pos_type;

   localparam pos_type POS_START = '0;

   // Decoded configuration handed from the register block to the walker.
   typedef struct packed {
      logic [SIZE_W-1:0]        k;
      detail_type [3:0]         detail;
      logic [GROUP_N-1:0]       fresh_valid;
   } cfg_type;

   typedef struct packed {
      logic [CW-1:0] x;
      logic [CW-1:0] z;
   } point_type;

   typedef struct packed {
      logic      found;
      logic      last;
      side_type  side;
   } walk_status_type;

   typedef struct packed {
      logic      found;
      group_type idx;
   } pick_type;

   // Lowest set bit of a group vector.
   function automatic pick_type first_set(input logic [GROUP_N-1:0] vec);
      pick_type p;
      p = '0;
      for (int i = GROUP_N - 1; i >= 0; i--) begin
         if (vec[i]) begin
            p.found = 1'b1;
            p.idx   = GROUP_W'(i);
         end
      end
      return p;
   endfunction

   // Groups strictly after the given one.
   function automatic logic [GROUP_N-1:0] above_mask(input group_type g);
      return ({GROUP_N{1'b1}} << 1) << g;
   endfunction

   // Counter values on entry to a group.
   function automatic pos_type fresh_pos(input group_type g, input detail_type lod);
      pos_type p;
      p      = POS_START;
      p.sec  = section_type'(g[3:2]);
      p.side = side_type'(g[1:0]);
      if (p.sec == SEC_STITCH) begin
         if (lod == DETAIL_W'(1)) begin
            p.base = CNT_W'(1);
            p.half = 1'b1;
         end else begin
            p.phase = PHASE_W'(1);
         end
      end
      return p;
   endfunction

   function automatic point_type mk_pt(input logic [CW-1:0] x, input logic [CW-1:0] z);
      point_type p;
      p.x = x;
      p.z = z;
      return p;
   endfunction

endpackage

@@ rtl/lgti_csr.sv @@
// Configuration registers and the per-group entry checks derived from them.
module lgti_csr import lgti_pkg::*; #(
   parameter int MAX_SIZE_LOG2 = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_wr_en,
   input  logic [CSR_INDEX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_wdata,
   output cfg_type                 cfg,
   output logic [MAX_SIZE_LOG2:0]  grid_max
);

   localparam int MW = MAX_SIZE_LOG2 + 1;
   localparam logic [SIZE_W-1:0] KMAX = SIZE_W'(MAX_SIZE_LOG2);

   logic [SIZE_W-1:0]  size_ff, size_in;
   detail_type [3:0]   detail_ff, detail_in;
   logic [SIZE_W-1:0]  k;
   logic [GROUP_N-1:0] fresh_valid;
   logic [CW-1:0]      m_w;
   logic               more_than_two;

   // Register writes.
   always_comb begin
      size_in   = size_ff;
      detail_in = detail_ff;
      if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_SIZE_LOG2: size_in = csr_wdata[SIZE_W-1:0];
            CSR_NORTH:     detail_in[SIDE_NORTH] = csr_wdata;
            CSR_SOUTH:     detail_in[SIDE_SOUTH] = csr_wdata;
            CSR_WEST:      detail_in[SIDE_WEST]  = csr_wdata;
            CSR_EAST:      detail_in[SIDE_EAST]  = csr_wdata;
            default:       ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff   <= SIZE_RESET;
         detail_ff <= '0;
      end else begin
         size_ff   <= size_in;
         detail_ff <= detail_in;
      end
   end

   // Clamp the size to the supported range and form R - 1.
   always_comb begin
      if (size_ff == '0) begin
         k = SIZE_W'(1);
      end else if (size_ff > KMAX) begin
         k = KMAX;
      end else begin
         k = size_ff;
      end
   end

   assign grid_max      = MW'(1) << k;
   assign m_w           = CW'(grid_max);
   assign more_than_two = (m_w > CW'(2));

   // A group is worth entering when its first triangle exists.
   always_comb begin
      fresh_valid = '0;
      for (int s = 0; s < 4; s++) begin
         fresh_valid[s]      = (detail_ff[s] != '0) &&
                               (CW'({detail_ff[s], 1'b0}) <= m_w);
         fresh_valid[4 + s]  = (detail_ff[s] != '0) && more_than_two;
         fresh_valid[12 + s] = (detail_ff[s] == '0);
      end
      fresh_valid[{SEC_INTERIOR, SIDE_NORTH}] = more_than_two;
   end

   assign cfg.k           = k;
   assign cfg.detail      = detail_ff;
   assign cfg.fresh_valid = fresh_valid;

endmodule

@@ rtl/lgti_coord.sv @@
// Grid point to vertex index: clamp, rotate to the side and fold to x + z * R.
module lgti_coord import lgti_pkg::*; #(
   parameter int MAX_SIZE_LOG2 = 8
) (
   input  point_type               pt,
   input  side_type                side,
   input  logic [MAX_SIZE_LOG2:0]  grid_max,
   input  logic [SIZE_W-1:0]       k,
   output logic [VERTEX_W-1:0]     vertex
);

   localparam int MW = MAX_SIZE_LOG2 + 1;
   localparam int VW = (2 * MW > VERTEX_W) ? 2 * MW : VERTEX_W;

   logic [CW-1:0] m_w;
   logic [MW-1:0] xs, zs, cx, cz;
   logic [VW-1:0] v;

   assign m_w = CW'(grid_max);

   // Points past the far edge sit on the edge.
   assign xs = (pt.x > m_w) ? grid_max : pt.x[MW-1:0];
   assign zs = (pt.z > m_w) ? grid_max : pt.z[MW-1:0];

   // Each side is the north geometry rotated.
   always_comb begin
      case (side)
         SIDE_NORTH: begin
            cx = xs;
            cz = zs;
         end
         SIDE_SOUTH: begin
            cx = grid_max - xs;
            cz = grid_max - zs;
         end
         SIDE_WEST: begin
            cx = zs;
            cz = grid_max - xs;
         end
         SIDE_EAST: begin
            cx = grid_max - zs;
            cz = xs;
         end
         default: begin
            cx = xs;
            cz = zs;
         end
      endcase
   end

   // R is 2^k + 1, so z * R is a shift and an add.
   assign v      = VW'(cx) + (VW'(cz) << k) + VW'(cz);
   assign vertex = v[VERTEX_W-1:0];

endmodule

@@ rtl/lgti_walk.sv @@
// List position register with settle, triangle point generation and advance.
module lgti_walk import lgti_pkg::*; #(
   parameter int MAX_SIZE_LOG2 = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    fire,
   input  logic                    restart,
   input  cfg_type                 cfg,
   input  logic [MAX_SIZE_LOG2:0]  grid_max,
   output point_type [2:0]         pts,
   output walk_status_type         status
);

   pos_type           pos_ff, pos_in;
   logic [CW-1:0]     m_w;
   detail_type        lod_r, s_lod;
   logic [2*CNT_W-1:0] prod;
   logic              reg_ok, cur_ok, use_reg, found;
   group_type         cur_g, s_g;
   pick_type          pick_after, pick_any, pick_next;
   pos_type           s_pos, a_pos;
   logic [CW-1:0]     s_x0, s_d, s_lodw, a_x0;
   logic [CW-1:0]     col_w, row_w, xi, zi, xs;
   logic              par, npar, nbit;
   logic [CNT_W:0]    colp1;
   logic [PHASE_W-1:0] ph;
   logic              a_ok, last;

   // Whether a position inside its group still names a triangle.
   function automatic logic group_ok(input section_type sec, input detail_type lod,
                                     input logic [CNT_W-1:0] row,
                                     input logic [CNT_W-1:0] col,
                                     input logic [CW-1:0] x0, input logic [CW-1:0] mw);
      logic [CW-1:0] d;
      logic          ok;
      d = CW'({lod, 1'b0});
      case (sec)
         SEC_WEDGE:    ok = (lod != '0) && (x0 + d <= mw);
         SEC_STITCH:   ok = (lod != '0) && (CW'(col) < mw - CW'(2));
         SEC_INTERIOR: ok = (CW'(row) < mw - CW'(2)) && (CW'(col) < mw - CW'(2));
         SEC_BORDER:   ok = (lod == '0) && (CW'(col) <= mw - CW'(1));
         default:      ok = 1'b0;
      endcase
      return ok;
   endfunction

   assign m_w   = CW'(grid_max);
   assign lod_r = cfg.detail[pos_ff.side];

   // Wedge x origin of the stored position: col times the wedge width.
   assign prod = pos_ff.col * CNT_W'({lod_r, 1'b0});

   // Settle: keep the stored position (on restart, the entry of group 0), else enter the next
   // non-empty group, else wrap to the first non-empty group.
   assign reg_ok     = group_ok(pos_ff.sec, lod_r, pos_ff.row, pos_ff.col, CW'(prod), m_w);
   assign cur_g      = restart ? START_GROUP : {pos_ff.sec, pos_ff.side};
   assign cur_ok     = restart ? cfg.fresh_valid[START_GROUP] : reg_ok;
   assign use_reg    = cur_ok && !restart;
   assign pick_after = first_set(cfg.fresh_valid & above_mask(cur_g));
   assign pick_any   = first_set(cfg.fresh_valid);
   assign found      = cur_ok || pick_any.found;

   always_comb begin
      if (cur_ok) begin
         s_g = cur_g;
      end else if (pick_after.found) begin
         s_g = pick_after.idx;
      end else begin
         s_g = pick_any.idx;
      end
   end

   assign s_pos  = use_reg ? pos_ff : fresh_pos(s_g, cfg.detail[s_g[1:0]]);
   assign s_lod  = cfg.detail[s_pos.side];
   assign s_lodw = CW'(s_lod);
   assign s_d    = CW'({s_lod, 1'b0});
   assign s_x0   = use_reg ? CW'(prod) : '0;
   assign col_w  = CW'(s_pos.col);
   assign row_w  = CW'(s_pos.row);
   assign xi     = col_w + CW'(1);
   assign zi     = row_w + CW'(1);
   assign par    = xi[0] ^ zi[0];
   assign npar   = ~par;
   assign nbit   = ~s_pos.col[0];
   assign xs     = CW'(s_pos.base) + (s_pos.half ? s_lodw : '0);

   // Triangle points in the north frame.
   always_comb begin
      case (s_pos.sec)
         SEC_WEDGE: begin
            pts[0] = mk_pt(s_x0, '0);
            pts[1] = mk_pt(s_x0 + s_d, '0);
            pts[2] = mk_pt(s_x0 + s_lodw, CW'(1));
         end
         SEC_STITCH: begin
            pts[0] = mk_pt(xs, '0);
            pts[1] = mk_pt(col_w + CW'(2), CW'(1));
            pts[2] = mk_pt(col_w + CW'(1), CW'(1));
         end
         SEC_INTERIOR: begin
            if (!s_pos.half) begin
               pts[0] = mk_pt(xi, zi);
               pts[1] = mk_pt(xi + CW'(1), zi);
               pts[2] = mk_pt(xi + CW'(npar), zi + CW'(1));
            end else begin
               pts[0] = mk_pt(xi + CW'(par), zi);
               pts[1] = mk_pt(xi + CW'(1), zi + CW'(1));
               pts[2] = mk_pt(xi, zi + CW'(1));
            end
         end
         SEC_BORDER: begin
            if (col_w == '0) begin
               // Corner triangle at the start of the strip.
               pts[0] = mk_pt('0, '0);
               pts[1] = mk_pt(CW'(1), '0);
               pts[2] = mk_pt(CW'(1), CW'(1));
            end else if (col_w >= m_w - CW'(1)) begin
               // Corner triangle at the end of the strip.
               pts[0] = mk_pt(m_w - CW'(1), CW'(1));
               pts[1] = mk_pt(m_w - CW'(1), '0);
               pts[2] = mk_pt(m_w, '0);
            end else if (!s_pos.half) begin
               pts[0] = mk_pt(col_w, '0);
               pts[1] = mk_pt(col_w + CW'(1), '0);
               pts[2] = mk_pt(col_w + CW'(nbit), CW'(1));
            end else begin
               pts[0] = mk_pt(col_w + CW'(s_pos.col[0]), '0);
               pts[1] = mk_pt(col_w + CW'(1), CW'(1));
               pts[2] = mk_pt(col_w, CW'(1));
            end
         end
         default: begin
            pts[0] = mk_pt('0, '0);
            pts[1] = mk_pt('0, '0);
            pts[2] = mk_pt('0, '0);
         end
      endcase
   end

   // Advance the counters of the current group.
   assign colp1 = {1'b0, s_pos.col} + (CNT_W + 1)'(1);
   assign ph    = s_pos.phase + PHASE_W'(1);

   always_comb begin
      a_pos = s_pos;
      case (s_pos.sec)
         SEC_WEDGE: begin
            a_pos.col = colp1[CNT_W-1:0];
         end
         SEC_STITCH: begin
            // The phase counts t mod lod; base steps by lod on each rollover.
            a_pos.col = colp1[CNT_W-1:0];
            if (ph >= s_lod) begin
               a_pos.phase = '0;
               a_pos.base  = s_pos.base + CNT_W'(s_lod);
               a_pos.half  = ~s_pos.half;
            end else begin
               a_pos.phase = ph;
            end
         end
         SEC_INTERIOR: begin
            if (!s_pos.half) begin
               a_pos.half = 1'b1;
            end else begin
               a_pos.half = 1'b0;
               if (CW'(colp1) >= m_w - CW'(2)) begin
                  a_pos.col = '0;
                  a_pos.row = s_pos.row + CNT_W'(1);
               end else begin
                  a_pos.col = colp1[CNT_W-1:0];
               end
            end
         end
         SEC_BORDER: begin
            if ((s_pos.col != '0) && (col_w <= m_w - CW'(2)) && !s_pos.half) begin
               a_pos.half = 1'b1;
            end else begin
               a_pos.half = 1'b0;
               a_pos.col  = colp1[CNT_W-1:0];
            end
         end
         default: ;
      endcase
   end

   // The wedge origin moves by one wedge width unless the column wrapped.
   assign a_x0      = (a_pos.col == '0) ? '0 : s_x0 + s_d;
   assign a_ok      = group_ok(s_pos.sec, s_lod, a_pos.row, a_pos.col, a_x0, m_w);
   assign pick_next = first_set(cfg.fresh_valid & above_mask(s_g));
   assign last      = !a_ok && !pick_next.found;

   // Next position: stay in the group, enter the next one, or wrap.
   always_comb begin
      if (!found) begin
         pos_in = POS_START;
      end else if (a_ok) begin
         pos_in = a_pos;
      end else if (pick_next.found) begin
         pos_in = fresh_pos(pick_next.idx, cfg.detail[pick_next.idx[1:0]]);
      end else begin
         pos_in = POS_START;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= POS_START;
      end else if (fire) begin
         pos_ff <= pos_in;
      end
   end

   assign status.found = found;
   assign status.last  = last;
   assign status.side  = s_pos.side;

   // An empty list leaves the position at the start.
   assert property (@(posedge clock) disable iff (reset)
      fire && !status.found |=> pos_ff == POS_START)
      else $error("position not at start after an empty list");

   // The list wraps to the start after its final triangle.
   assert property (@(posedge clock) disable iff (reset)
      fire && status.found && status.last |=> pos_ff == POS_START)
      else $error("position not at start after the final triangle");

   // A position that is kept after a triangle lies in a non-empty group.
   assert property (@(posedge clock) disable iff (reset)
      fire && status.found && !status.last |-> cfg.fresh_valid[{pos_in.sec, pos_in.side}])
      else $error("next position lies in an empty group");

endmodule

@@ rtl/lod_grid_triangle_index_generator.sv @@
// Top level of the LOD grid triangle index generator: handshake, registers and datapath.
//
//   Channel   Direction  Handshake              Payload
//   req       in         req_valid / req_stall  req_restart
//   rsp       out        rsp_valid / rsp_stall  rsp_vertex_a/b/c, rsp_last_triangle
//   csr       in         csr_wr_en              csr_index, csr_wdata
//
// One triangle per clock sustained while rsp is not stalled; a response reaches rsp after its
// request transfer through the input register, then the output register.
// Reset is synchronous; it restores size_log2 = 4, all details 0 and the list start.
// A held rsp stalls the input register, which stalls req only while it is full.
// A request over an empty list produces no response.
module lod_grid_triangle_index_generator import lgti_pkg::*; #(
   parameter int MAX_SIZE_LOG2 = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic                    req_restart,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [VERTEX_W-1:0]     rsp_vertex_a,
   output logic [VERTEX_W-1:0]     rsp_vertex_b,
   output logic [VERTEX_W-1:0]     rsp_vertex_c,
   output logic                    rsp_last_triangle,
   input  logic                    csr_wr_en,
   input  logic [CSR_INDEX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_wdata
);

   cfg_type                 cfg;
   logic [MAX_SIZE_LOG2:0]  grid_max;
   point_type [2:0]         pts;
   walk_status_type         status;
   logic [VERTEX_W-1:0]     vtx [3];

   logic                    in_valid_ff, in_valid_in;
   logic                    in_restart_ff, in_restart_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [VERTEX_W-1:0]     vtx_a_ff, vtx_a_in;
   logic [VERTEX_W-1:0]     vtx_b_ff, vtx_b_in;
   logic [VERTEX_W-1:0]     vtx_c_ff, vtx_c_in;
   logic                    last_ff, last_in;
   logic                    out_free, fire, req_xfer, load;

   lgti_csr #(
      .MAX_SIZE_LOG2 (MAX_SIZE_LOG2)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg),
      .grid_max  (grid_max)
   );

   lgti_walk #(
      .MAX_SIZE_LOG2 (MAX_SIZE_LOG2)
   ) u_walk (
      .clock    (clock),
      .reset    (reset),
      .fire     (fire),
      .restart  (in_restart_ff),
      .cfg      (cfg),
      .grid_max (grid_max),
      .pts      (pts),
      .status   (status)
   );

   // One index unit per triangle corner.
   for (genvar i = 0; i < 3; i++) begin : g_coord
      lgti_coord #(
         .MAX_SIZE_LOG2 (MAX_SIZE_LOG2)
      ) u_coord (
         .pt       (pts[i]),
         .side     (status.side),
         .grid_max (grid_max),
         .k        (cfg.k),
         .vertex   (vtx[i])
      );
   end

   // Handshake: the input register moves on whenever the output register can take it.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign fire      = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_xfer  = req_valid && !req_stall;
   assign load      = fire && status.found;

   always_comb begin
      if (req_xfer) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   assign in_restart_in = req_xfer ? req_restart : in_restart_ff;
   assign rsp_valid_in  = out_free ? load : rsp_valid_ff;

   // Output payload loads only with a new triangle.
   assign vtx_a_in = load ? vtx[0] : vtx_a_ff;
   assign vtx_b_in = load ? vtx[1] : vtx_b_ff;
   assign vtx_c_in = load ? vtx[2] : vtx_c_ff;
   assign last_in  = load ? status.last : last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_restart_ff <= in_restart_in;
      vtx_a_ff      <= vtx_a_in;
      vtx_b_ff      <= vtx_b_in;
      vtx_c_ff      <= vtx_c_in;
      last_ff       <= last_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_vertex_a      = vtx_a_ff;
   assign rsp_vertex_b      = vtx_b_ff;
   assign rsp_vertex_c      = vtx_c_ff;
   assign rsp_last_triangle = last_ff;

   // A request held in the input register keeps its restart flag while blocked.
   assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !out_free |=> in_valid_ff && $stable(in_restart_ff))
      else $error("blocked request lost or changed");

   // A response taken with nothing new behind it leaves the output empty.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_stall && !fire |=> !rsp_valid_ff)
      else $error("response repeated after its transfer");

endmodule
